@@ rtl/mpfl_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-pool free list allocator package
// Shared constants, operation and status codes, and the structs that pass
// between the pool controller, the slot store and the top level.
// ----------------------------------------------------------------------------
package mpfl_pkg;

    localparam int NUM_POOLS_DEF      = 4;
    localparam int SLOTS_PER_POOL_DEF = 256;

    localparam int NUM_REGS    = 4;
    localparam int REG_IDX_W   = 2;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam int OP_W        = 2;
    localparam int POOL_SEL_W  = 2;
    localparam int SLOT_W      = 9;
    localparam int STATUS_W    = 3;
    localparam int GRANT_W     = 8;
    localparam int CNT_W       = 9;
    localparam int OVF_W       = 16;

    localparam logic [CNT_W-1:0] POOL_SIZE_RESET = CNT_W'(256);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_ENABLE  = 2'd2,
        OP_DISABLE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_OVERFLOW    = 3'd1,
        ST_DISABLED    = 3'd2,
        ST_DOUBLE_FREE = 3'd3,
        ST_NO_CHANGE   = 3'd4
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [GRANT_W-1:0] granted_slot;
        logic [CNT_W-1:0]   in_use;
        logic [CNT_W-1:0]   peak_in_use;
        logic [OVF_W-1:0]   overflow_count;
        logic               overflow_seen;
    } result_t;

    typedef struct packed {
        logic link_we;
        logic taken_we;
        logic taken_bit;
    } slot_wr_t;

endpackage

@@ rtl/mpfl_slot_store.sv @@
// ----------------------------------------------------------------------------
// Slot store
// Link memory and allocated-mark memory for all pools, one read port and
// one write port each, with registered read data.
// ----------------------------------------------------------------------------
module mpfl_slot_store #(
    parameter int NUM_POOLS      = mpfl_pkg::NUM_POOLS_DEF,
    parameter int SLOTS_PER_POOL = mpfl_pkg::SLOTS_PER_POOL_DEF,
    localparam int IDX_W         = $clog2(SLOTS_PER_POOL),
    localparam int DEPTH         = NUM_POOLS * SLOTS_PER_POOL,
    localparam int ADDR_W        = $clog2(DEPTH)
) (
    input  logic                              aclk,
    input  logic                              rd_en,
    input  logic [mpfl_pkg::POOL_SEL_W-1:0]   rd_pool,
    input  logic [IDX_W-1:0]                  rd_head,
    input  logic [mpfl_pkg::SLOT_W-1:0]       rd_slot,
    output logic [IDX_W-1:0]                  link_rd_data,
    output logic                              taken_rd_data,
    input  mpfl_pkg::slot_wr_t                slot_wr,
    input  logic [mpfl_pkg::POOL_SEL_W-1:0]   wr_pool,
    input  logic [IDX_W-1:0]                  wr_idx,
    input  logic [IDX_W-1:0]                  wr_link
);
    import mpfl_pkg::*;

    logic [IDX_W-1:0]  link_mem [DEPTH];
    logic              taken_mem [DEPTH];
    logic [IDX_W-1:0]  link_rd_reg;
    logic              taken_rd_reg;
    logic [ADDR_W-1:0] link_rd_addr;
    logic [ADDR_W-1:0] taken_rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign link_rd_addr  = ADDR_W'(int'(rd_pool) * SLOTS_PER_POOL + int'(rd_head));
    assign taken_rd_addr = ADDR_W'(int'(rd_pool) * SLOTS_PER_POOL
                                   + int'(IDX_W'(rd_slot)));
    assign wr_addr       = ADDR_W'(int'(wr_pool) * SLOTS_PER_POOL + int'(wr_idx));

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            link_rd_reg  <= link_mem[link_rd_addr];
            taken_rd_reg <= taken_mem[taken_rd_addr];
        end
        if (slot_wr.link_we) begin
            link_mem[wr_addr] <= wr_link;
        end
        if (slot_wr.taken_we) begin
            taken_mem[wr_addr] <= slot_wr.taken_bit;
        end
    end

    assign link_rd_data  = link_rd_reg;
    assign taken_rd_data = taken_rd_reg;

endmodule

@@ rtl/mpfl_pool_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pool controller
// Per-pool head, counts, flags and build watermark, and the decision logic
// that turns one request and the slot store read data into a result.
// ----------------------------------------------------------------------------
module mpfl_pool_ctrl #(
    parameter int NUM_POOLS      = mpfl_pkg::NUM_POOLS_DEF,
    parameter int SLOTS_PER_POOL = mpfl_pkg::SLOTS_PER_POOL_DEF,
    localparam int IDX_W         = $clog2(SLOTS_PER_POOL),
    localparam int WM_W          = $clog2(SLOTS_PER_POOL + 1),
    localparam int POOL_W        = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [mpfl_pkg::POOL_SEL_W-1:0]   acc_pool,
    input  logic                              commit,
    input  mpfl_pkg::op_t                     req_op,
    input  logic [mpfl_pkg::POOL_SEL_W-1:0]   req_pool,
    input  logic [mpfl_pkg::SLOT_W-1:0]       req_slot,
    input  logic [mpfl_pkg::CNT_W-1:0]        req_size,
    input  logic [IDX_W-1:0]                  link_rd_data,
    input  logic                              taken_rd_data,
    output logic [IDX_W-1:0]                  rd_head,
    output mpfl_pkg::result_t                 result,
    output mpfl_pkg::slot_wr_t                slot_wr,
    output logic [IDX_W-1:0]                  wr_idx,
    output logic [IDX_W-1:0]                  wr_link
);
    import mpfl_pkg::*;

    logic [IDX_W-1:0] head_reg [NUM_POOLS];
    logic [CNT_W-1:0] used_reg [NUM_POOLS];
    logic [CNT_W-1:0] peak_reg [NUM_POOLS];
    logic [OVF_W-1:0] ovf_reg  [NUM_POOLS];
    logic             seen_reg [NUM_POOLS];
    logic             en_reg   [NUM_POOLS];
    logic [WM_W-1:0]  wm_reg   [NUM_POOLS];
    logic [IDX_W-1:0] req_head_reg;

    logic [POOL_W-1:0] pidx;
    logic              pool_ok;
    logic [IDX_W-1:0]  head_next;
    logic [CNT_W-1:0]  used_next;
    logic [CNT_W-1:0]  peak_next;
    logic [OVF_W-1:0]  ovf_next;
    logic              seen_next;
    logic              en_next;
    logic [WM_W-1:0]   wm_next;
    logic [IDX_W-1:0]  slot_idx;
    logic              head_fresh;
    logic              slot_taken;
    logic [IDX_W-1:0]  pop_link;
    status_t           status;
    logic [IDX_W-1:0]  granted;

    assign rd_head = head_reg[POOL_W'(acc_pool)];
    assign pidx    = POOL_W'(req_pool);
    assign pool_ok = int'(req_pool) < NUM_POOLS;

    // Slots at or above the watermark have never been handed out since the
    // pool was built, so they read as free and linked to the next slot.
    assign slot_idx   = IDX_W'(req_slot);
    assign head_fresh = WM_W'(req_head_reg) >= wm_reg[pidx];
    assign slot_taken = taken_rd_data && (WM_W'(slot_idx) < wm_reg[pidx]);

    always_comb begin
        if (!head_fresh) begin
            pop_link = link_rd_data;
        end else if (WM_W'(req_head_reg) + WM_W'(1) == WM_W'(SLOTS_PER_POOL)) begin
            pop_link = '0;
        end else begin
            pop_link = IDX_W'(req_head_reg + IDX_W'(1));
        end
    end

    always_comb begin
        head_next = head_reg[pidx];
        used_next = used_reg[pidx];
        peak_next = peak_reg[pidx];
        ovf_next  = ovf_reg[pidx];
        seen_next = seen_reg[pidx];
        en_next   = en_reg[pidx];
        wm_next   = wm_reg[pidx];
        status    = ST_OK;
        granted   = '0;
        slot_wr   = '0;
        wr_idx    = slot_idx;
        wr_link   = req_head_reg;
        case (req_op)
            OP_ALLOC: begin
                if (!en_reg[pidx]) begin
                    status = ST_DISABLED;
                end else if (used_reg[pidx] >= req_size) begin
                    status    = ST_OVERFLOW;
                    seen_next = 1'b1;
                    if (ovf_reg[pidx] != '1) begin
                        ovf_next = ovf_reg[pidx] + OVF_W'(1);
                    end
                end else begin
                    granted           = req_head_reg;
                    head_next         = pop_link;
                    used_next         = used_reg[pidx] + CNT_W'(1);
                    wr_idx            = req_head_reg;
                    slot_wr.taken_we  = 1'b1;
                    slot_wr.taken_bit = 1'b1;
                    if (used_next > peak_reg[pidx]) begin
                        peak_next = used_next;
                    end
                    if (head_fresh) begin
                        wm_next = WM_W'(req_head_reg) + WM_W'(1);
                    end
                end
            end
            OP_FREE: begin
                if (!en_reg[pidx]) begin
                    status = ST_DISABLED;
                end else if (req_slot >= req_size) begin
                    if (ovf_reg[pidx] == '0) begin
                        status = ST_NO_CHANGE;
                    end else begin
                        ovf_next = ovf_reg[pidx] - OVF_W'(1);
                    end
                end else if (!slot_taken) begin
                    status = ST_DOUBLE_FREE;
                end else begin
                    slot_wr.taken_we  = 1'b1;
                    slot_wr.taken_bit = 1'b0;
                    slot_wr.link_we   = 1'b1;
                    head_next         = slot_idx;
                    if (used_reg[pidx] != '0) begin
                        used_next = used_reg[pidx] - CNT_W'(1);
                    end
                end
            end
            OP_ENABLE: begin
                if (en_reg[pidx]) begin
                    status = ST_NO_CHANGE;
                end else begin
                    head_next = '0;
                    used_next = '0;
                    peak_next = '0;
                    ovf_next  = '0;
                    seen_next = 1'b0;
                    en_next   = 1'b1;
                    wm_next   = '0;
                end
            end
            OP_DISABLE: begin
                if (!en_reg[pidx]) begin
                    status = ST_NO_CHANGE;
                end else begin
                    en_next = 1'b0;
                end
            end
            default: begin
                status = ST_NO_CHANGE;
            end
        endcase
        if (!pool_ok || !commit) begin
            slot_wr = '0;
        end
    end

    always_comb begin
        if (pool_ok) begin
            result.status         = status;
            result.granted_slot   = GRANT_W'(granted);
            result.in_use         = used_next;
            result.peak_in_use    = peak_next;
            result.overflow_count = ovf_next;
            result.overflow_seen  = seen_next;
        end else begin
            result        = '0;
            result.status = ST_DISABLED;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_head_reg <= rd_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_POOLS; i++) begin
                head_reg[i] <= '0;
                used_reg[i] <= '0;
                peak_reg[i] <= '0;
                ovf_reg[i]  <= '0;
                seen_reg[i] <= 1'b0;
                en_reg[i]   <= 1'b1;
                wm_reg[i]   <= '0;
            end
        end else if (commit && pool_ok) begin
            head_reg[pidx] <= head_next;
            used_reg[pidx] <= used_next;
            peak_reg[pidx] <= peak_next;
            ovf_reg[pidx]  <= ovf_next;
            seen_reg[pidx] <= seen_next;
            en_reg[pidx]   <= en_next;
            wm_reg[pidx]   <= wm_next;
        end
    end

endmodule

@@ rtl/multi_pool_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// Multi-pool free list allocator
// Several pools of fixed slots, each with a last-in-first-out free list,
// allocated marks, usage and peak counts, and a saturating overflow count.
// ----------------------------------------------------------------------------
// A result is registered when its item commits, which can wait on m_ready.
// A new item is accepted only after the previous one has committed, set by the
// registered read of the link memory, which must finish before the next head can be read.
// Reset: all pools enabled and empty, sizes 256; the lists are built lazily
// behind a per-pool watermark, so no clearing pass is needed.
module multi_pool_free_list_allocator #(
    parameter int NUM_POOLS      = mpfl_pkg::NUM_POOLS_DEF,
    parameter int SLOTS_PER_POOL = mpfl_pkg::SLOTS_PER_POOL_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mpfl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mpfl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mpfl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mpfl_pkg::OP_W-1:0]         s_op,
    input  logic [mpfl_pkg::POOL_SEL_W-1:0]   s_pool,
    input  logic [mpfl_pkg::SLOT_W-1:0]       s_slot,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mpfl_pkg::STATUS_W-1:0]     m_status,
    output logic [mpfl_pkg::GRANT_W-1:0]      m_granted_slot,
    output logic [mpfl_pkg::CNT_W-1:0]        m_in_use,
    output logic [mpfl_pkg::CNT_W-1:0]        m_peak_in_use,
    output logic [mpfl_pkg::OVF_W-1:0]        m_overflow_count,
    output logic                              m_overflow_seen
);
    import mpfl_pkg::*;

    localparam int IDX_W = $clog2(SLOTS_PER_POOL);

    logic [CNT_W-1:0]      pool_size_reg [NUM_REGS];
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  busy_reg;
    logic                  m_valid_reg;
    op_t                   req_op_reg;
    logic [POOL_SEL_W-1:0] req_pool_reg;
    logic [SLOT_W-1:0]     req_slot_reg;
    logic [CNT_W-1:0]      req_size_reg;
    logic [CNT_W-1:0]      acc_size;
    result_t               result_reg;
    result_t               result;
    logic                  accept;
    logic                  commit;
    logic [IDX_W-1:0]      rd_head;
    logic [IDX_W-1:0]      link_rd_data;
    logic                  taken_rd_data;
    slot_wr_t              slot_wr;
    logic [IDX_W-1:0]      wr_idx;
    logic [IDX_W-1:0]      wr_link;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = APB_DATA_W'(pool_size_reg[reg_idx]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                pool_size_reg[i] <= POOL_SIZE_RESET;
            end
        end else if (psel && penable && pwrite) begin
            pool_size_reg[reg_idx] <= pwdata[CNT_W-1:0];
        end
    end

    assign s_ready = !busy_reg;
    assign accept  = s_valid && !busy_reg;
    assign commit  = busy_reg && (!m_valid_reg || m_ready);

    always_comb begin
        if (int'(pool_size_reg[s_pool]) > SLOTS_PER_POOL) begin
            acc_size = CNT_W'(SLOTS_PER_POOL);
        end else begin
            acc_size = pool_size_reg[s_pool];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (commit) begin
                busy_reg <= 1'b0;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_op_reg   <= op_t'(s_op);
            req_pool_reg <= s_pool;
            req_slot_reg <= s_slot;
            req_size_reg <= acc_size;
        end
        if (commit) begin
            result_reg <= result;
        end
    end

    mpfl_slot_store #(
        .NUM_POOLS      (NUM_POOLS),
        .SLOTS_PER_POOL (SLOTS_PER_POOL)
    ) u_slot_store (
        .aclk          (aclk),
        .rd_en         (accept),
        .rd_pool       (s_pool),
        .rd_head       (rd_head),
        .rd_slot       (s_slot),
        .link_rd_data  (link_rd_data),
        .taken_rd_data (taken_rd_data),
        .slot_wr       (slot_wr),
        .wr_pool       (req_pool_reg),
        .wr_idx        (wr_idx),
        .wr_link       (wr_link)
    );

    mpfl_pool_ctrl #(
        .NUM_POOLS      (NUM_POOLS),
        .SLOTS_PER_POOL (SLOTS_PER_POOL)
    ) u_pool_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .acc_pool      (s_pool),
        .commit        (commit),
        .req_op        (req_op_reg),
        .req_pool      (req_pool_reg),
        .req_slot      (req_slot_reg),
        .req_size      (req_size_reg),
        .link_rd_data  (link_rd_data),
        .taken_rd_data (taken_rd_data),
        .rd_head       (rd_head),
        .result        (result),
        .slot_wr       (slot_wr),
        .wr_idx        (wr_idx),
        .wr_link       (wr_link)
    );

    assign m_valid          = m_valid_reg;
    assign m_status         = result_reg.status;
    assign m_granted_slot   = result_reg.granted_slot;
    assign m_in_use         = result_reg.in_use;
    assign m_peak_in_use    = result_reg.peak_in_use;
    assign m_overflow_count = result_reg.overflow_count;
    assign m_overflow_seen  = result_reg.overflow_seen;

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (busy_reg && !s_ready))
        else $error("Input accepted while an item was still in progress.");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(busy_reg))
        else $error("Result appeared without an item in progress.");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (result_reg.in_use <= result_reg.peak_in_use))
        else $error("In-use count exceeds the peak count.");

    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.granted_slot != '0) |-> (result_reg.status == ST_OK))
        else $error("Slot granted with a status other than ok.");

    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.status == ST_OVERFLOW) |-> result_reg.overflow_seen)
        else $error("Overflow reported without the sticky flag set.");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Multi-pool free list allocator testbench
// Drives allocate, free, enable and disable requests into the allocator and
// programs the pool sizes over the register port. Every request is run through
// a behavioral copy of the pools, and each returned item is compared field by
// field with the oldest predicted result. Directed tests cover the corner cases
// and overflow counting; random traffic mixes legal alloc/free sequences with
// stray frees, pool toggling, size changes and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mpfl_pkg::*;

    localparam int POOLS        = NUM_POOLS_DEF;
    localparam int SLOTS        = SLOTS_PER_POOL_DEF;
    localparam int REG_SIZE_A   = 0;
    localparam int REG_SIZE_B   = 1;
    localparam int REG_SIZE_C   = 2;
    localparam int REG_SIZE_D   = 3;
    localparam int SETTLE_TICKS = 8;
    localparam int DRAIN_LIMIT  = 5000;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic [OP_W-1:0]       s_op;
    logic [POOL_SEL_W-1:0] s_pool;
    logic [SLOT_W-1:0]     s_slot;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [GRANT_W-1:0]    m_granted_slot;
    logic [CNT_W-1:0]      m_in_use;
    logic [CNT_W-1:0]      m_peak_in_use;
    logic [OVF_W-1:0]      m_overflow_count;
    logic                  m_overflow_seen;

    // Behavioral copy of the pools.
    logic [CNT_W-1:0]   size_reg   [POOLS];
    logic [7:0]         next_free  [POOLS][SLOTS];
    bit                 slot_busy  [POOLS][SLOTS];
    logic [7:0]         list_head  [POOLS];
    logic [CNT_W-1:0]   used_slots [POOLS];
    logic [CNT_W-1:0]   peak_slots [POOLS];
    logic [OVF_W-1:0]   ovf_total  [POOLS];
    logic               ovf_flag   [POOLS];
    logic               pool_on    [POOLS];

    result_t pending_results[$];
    int      mismatch_count;
    int      results_seen;
    bit      sender_idles;
    bit      receiver_stalls;
    int      hold_cycles;

    multi_pool_free_list_allocator i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_pool           (s_pool),
        .s_slot           (s_slot),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_slot   (m_granted_slot),
        .m_in_use         (m_in_use),
        .m_peak_in_use    (m_peak_in_use),
        .m_overflow_count (m_overflow_count),
        .m_overflow_seen  (m_overflow_seen)
    );

    initial begin
        aclk = 1'b0;
    end

    always #1 aclk = ~aclk;

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic rebuild_pool(input int p);
        for (int i = 0; i < SLOTS; i++) begin
            next_free[p][i] = 8'(i + 1);
            slot_busy[p][i] = 1'b0;
        end
        list_head[p]  = '0;
        used_slots[p] = '0;
        peak_slots[p] = '0;
        ovf_total[p]  = '0;
        ovf_flag[p]   = 1'b0;
        pool_on[p]    = 1'b1;
    endtask

    task automatic apply_request(input op_t op, input int p, input logic [SLOT_W-1:0] slot,
                                 output result_t res);
        int unsigned pool_len;
        pool_len = (size_reg[p] > SLOTS) ? SLOTS : size_reg[p];
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_ALLOC: begin
                if (!pool_on[p]) begin
                    res.status = ST_DISABLED;
                end else if (used_slots[p] >= pool_len) begin
                    res.status = ST_OVERFLOW;
                    if (ovf_total[p] != 16'hFFFF) ovf_total[p]++;
                    ovf_flag[p] = 1'b1;
                end else begin
                    res.granted_slot = list_head[p];
                    slot_busy[p][list_head[p]] = 1'b1;
                    list_head[p] = next_free[p][list_head[p]];
                    used_slots[p]++;
                    if (used_slots[p] > peak_slots[p]) peak_slots[p] = used_slots[p];
                end
            end
            OP_FREE: begin
                if (!pool_on[p]) begin
                    res.status = ST_DISABLED;
                end else if (slot >= pool_len) begin
                    if (ovf_total[p] == 0) res.status = ST_NO_CHANGE;
                    else ovf_total[p]--;
                end else if (!slot_busy[p][slot[7:0]]) begin
                    res.status = ST_DOUBLE_FREE;
                end else begin
                    slot_busy[p][slot[7:0]] = 1'b0;
                    next_free[p][slot[7:0]] = list_head[p];
                    list_head[p] = slot[7:0];
                    if (used_slots[p] != 0) used_slots[p]--;
                end
            end
            OP_ENABLE: begin
                if (pool_on[p]) res.status = ST_NO_CHANGE;
                else rebuild_pool(p);
            end
            default: begin
                if (!pool_on[p]) res.status = ST_NO_CHANGE;
                else pool_on[p] = 1'b0;
            end
        endcase
        res.in_use         = used_slots[p];
        res.peak_in_use    = peak_slots[p];
        res.overflow_count = ovf_total[p];
        res.overflow_seen  = ovf_flag[p];
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at result %0d: %s got %0d expected %0d", results_seen, what, got,
                 want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [OVF_W-1:0] got,
                               input logic [OVF_W-1:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item, status", m_status, 0);
            end else begin
                want = pending_results.pop_front();
                check_field("status", m_status, want.status);
                check_field("granted_slot", m_granted_slot, want.granted_slot);
                check_field("in_use", m_in_use, want.in_use);
                check_field("peak_in_use", m_peak_in_use, want.peak_in_use);
                check_field("overflow_count", m_overflow_count, want.overflow_count);
                check_field("overflow_seen", m_overflow_seen, want.overflow_seen);
            end
            results_seen++;
        end
    end

    // The result side stalls in random bursts, or for a long hold when asked.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input op_t op, input int p, input logic [SLOT_W-1:0] slot);
        result_t res;
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_pool  <= POOL_SEL_W'(p);
        s_slot  <= slot;
        do @(posedge aclk); while (!s_ready);
        apply_request(op, p, slot, res);
        pending_results.push_back(res);
    endtask

    task automatic wait_drained();
        int ticks;
        s_valid <= 1'b0;
        ticks = 0;
        while (pending_results.size() != 0 && ticks < DRAIN_LIMIT) begin
            @(posedge aclk);
            ticks++;
        end
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic cfg_write(input int idx, input logic [CNT_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_reg[idx] = value;
    endtask

    task automatic write_sizes(input int a, input int b, input int c, input int d);
        cfg_write(REG_SIZE_A, CNT_W'(a));
        cfg_write(REG_SIZE_B, CNT_W'(b));
        cfg_write(REG_SIZE_C, CNT_W'(c));
        cfg_write(REG_SIZE_D, CNT_W'(d));
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2, 3, 4: return $urandom_range(2, 12);
            5:       return $urandom_range(13, 255);
            6:       return SLOTS;
            7:       return $urandom_range(257, 511);
            default: return $urandom_range(0, 511);
        endcase
    endfunction

    // Returns a taken slot of pool p starting from a random point, or a random
    // slot number when the pool holds none.
    function automatic logic [SLOT_W-1:0] pick_busy_slot(input int p);
        int start;
        start = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_busy[p][(start + i) % SLOTS]) return SLOT_W'((start + i) % SLOTS);
        end
        return SLOT_W'($urandom_range(0, 511));
    endfunction

    task automatic send_random_item();
        int p;
        int r;
        p = $urandom_range(0, POOLS - 1);
        r = $urandom_range(0, 99);
        if (r < 42) send_item(OP_ALLOC, p, SLOT_W'($urandom_range(0, 511)));
        else if (r < 78) send_item(OP_FREE, p, pick_busy_slot(p));
        else if (r < 88) send_item(OP_FREE, p, SLOT_W'($urandom_range(0, 511)));
        else if (r < 95) send_item(OP_ENABLE, p, SLOT_W'($urandom_range(0, 511)));
        else send_item(OP_DISABLE, p, SLOT_W'($urandom_range(0, 511)));
    endtask

    task automatic test_basic_ops();
        send_item(OP_ALLOC, 0, '0);
        send_item(OP_ALLOC, 0, '1);
        send_item(OP_FREE, 0, 9'd1);
        send_item(OP_ALLOC, 0, '0);
        send_item(OP_FREE, 0, 9'd5);
        send_item(OP_FREE, 0, 9'd255);
        send_item(OP_FREE, 0, 9'd256);
        send_item(OP_FREE, 0, 9'd511);
        send_item(OP_ENABLE, 1, '0);
        send_item(OP_DISABLE, 1, '0);
        send_item(OP_ALLOC, 1, '0);
        send_item(OP_FREE, 1, '0);
        send_item(OP_DISABLE, 1, '0);
        send_item(OP_ENABLE, 1, '0);
        send_item(OP_ALLOC, 3, '0);
        send_item(OP_DISABLE, 0, '0);
        send_item(OP_ENABLE, 0, '0);
        wait_drained();
    endtask

    task automatic test_size_extremes();
        write_sizes(0, 1, 2, 511);
        send_item(OP_ALLOC, 0, '0);
        send_item(OP_ALLOC, 0, '0);
        send_item(OP_FREE, 0, 9'd0);
        send_item(OP_FREE, 0, 9'd0);
        send_item(OP_ALLOC, 1, '0);
        send_item(OP_ALLOC, 1, '0);
        send_item(OP_FREE, 1, 9'd0);
        send_item(OP_ALLOC, 2, '0);
        send_item(OP_ALLOC, 2, '0);
        send_item(OP_ALLOC, 2, '0);
        send_item(OP_ALLOC, 3, '0);
        send_item(OP_FREE, 3, 9'd256);
        wait_drained();
        // Shrinking a pool below its taken slots turns them into overflow objects.
        cfg_write(REG_SIZE_C, CNT_W'(1));
        send_item(OP_FREE, 2, 9'd1);
        send_item(OP_ALLOC, 2, '0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        write_sizes(4, 256, 3, 9);
        hold_cycles = 300;
        repeat (48) send_random_item();
        wait_drained();
    endtask

    task automatic test_overflow_counting();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        cfg_write(REG_SIZE_A, CNT_W'(0));
        send_item(OP_DISABLE, 0, '0);
        send_item(OP_ENABLE, 0, '0);
        repeat (60) send_item(OP_ALLOC, 0, '0);
        send_item(OP_FREE, 0, 9'd300);
        send_item(OP_ALLOC, 0, '0);
        send_item(OP_ALLOC, 0, '0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int phases, input int items, input bit idles);
        for (int ph = 0; ph < phases; ph++) begin
            write_sizes(pick_size(), pick_size(), pick_size(), pick_size());
            sender_idles    = idles && (ph % 3 != 2);
            receiver_stalls = idles && (ph % 3 != 1);
            repeat (items) send_random_item();
            wait_drained();
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_op            = OP_ALLOC;
        s_pool          = '0;
        s_slot          = '0;
        mismatch_count  = 0;
        results_seen    = 0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        hold_cycles     = 0;
        for (int p = 0; p < POOLS; p++) begin
            size_reg[p] = POOL_SIZE_RESET;
            rebuild_pool(p);
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_size_extremes();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        test_random_traffic(3, 125, 1'b1);
        test_backpressure();
        test_overflow_counting();
        test_random_traffic(3, 125, 1'b1);
        test_random_traffic(2, 125, 1'b0);

        if (pending_results.size() != 0) begin
            report_mismatch("items never returned", 0, pending_results.size());
        end
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
